// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("concurrent assertion failed");

// An implication that must hold at every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("concurrent implication failed");

`endif

// File: rtl/core/jlcbf_pkg.sv
// Types and constants shared by the joint-limit barrier feasibility block.
package jlcbf_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int DIST_CFG_WIDTH  = 31;
  localparam int GAIN_WIDTH      = 24;
  localparam int CFG_DATA_WIDTH  = 31;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 24'd65536;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_SAFE_MARGIN = 2'd0,
    REG_BAND_REACH  = 2'd1,
    REG_GAIN_LOWER  = 2'd2,
    REG_GAIN_UPPER  = 2'd3
  } cfg_reg_t;

  // Per-joint decisions carried down the pipeline.
  typedef struct packed {
    logic checked;
    logic lower_active;
    logic upper_active;
  } joint_flags_t;

endpackage

// File: rtl/core/jlcbf_margin.sv
// Safe-band and influence-band test with registered distances to both safe edges.
module jlcbf_margin #(
  parameter int VALUE_WIDTH = 32,
  parameter int DIST_WIDTH  = 34
) (
  input  logic                                       clk,
  input  logic signed [VALUE_WIDTH-1:0]              joint_position,
  input  logic signed [VALUE_WIDTH-1:0]              position_min,
  input  logic signed [VALUE_WIDTH-1:0]              position_max,
  input  logic        [jlcbf_pkg::DIST_CFG_WIDTH-1:0] safe_margin,
  input  logic        [jlcbf_pkg::DIST_CFG_WIDTH-1:0] band_reach,
  output logic signed [DIST_WIDTH-1:0]               dist_lower_r,
  output logic signed [DIST_WIDTH-1:0]               dist_upper_r,
  output jlcbf_pkg::joint_flags_t                    flags_r
);

  logic signed [DIST_WIDTH-1:0] q_e, pmin_e, pmax_e, sd_e, id_e;
  logic signed [DIST_WIDTH-1:0] low_safe, up_safe;
  logic signed [DIST_WIDTH-1:0] dist_lower_nxt, dist_upper_nxt;
  jlcbf_pkg::joint_flags_t      flags_nxt;

  always_comb begin
    q_e    = DIST_WIDTH'(joint_position);
    pmin_e = DIST_WIDTH'(position_min);
    pmax_e = DIST_WIDTH'(position_max);
    sd_e   = DIST_WIDTH'($unsigned(safe_margin));
    id_e   = DIST_WIDTH'($unsigned(band_reach));

    low_safe = pmin_e + sd_e;
    up_safe  = pmax_e - sd_e;

    flags_nxt.checked      = (pmin_e < pmax_e) && (low_safe < up_safe);
    flags_nxt.lower_active = flags_nxt.checked && (q_e <= pmin_e + id_e);
    flags_nxt.upper_active = flags_nxt.checked && (q_e >= pmax_e - id_e);

    dist_lower_nxt = low_safe - q_e;
    dist_upper_nxt = up_safe - q_e;
  end

  always_ff @(posedge clk) begin
    dist_lower_r <= dist_lower_nxt;
    dist_upper_r <= dist_upper_nxt;
    flags_r      <= flags_nxt;
  end

endmodule

// File: rtl/core/jlcbf_bound.sv
// Barrier bound: registered gain times distance, floored to Q.16 and saturated.
module jlcbf_bound #(
  parameter int VALUE_WIDTH = 32,
  parameter int DIST_WIDTH  = 34
) (
  input  logic                                   clk,
  input  logic        [jlcbf_pkg::GAIN_WIDTH-1:0] gain,
  input  logic signed [DIST_WIDTH-1:0]           gap,
  output logic signed [VALUE_WIDTH-1:0]          bound
);

  localparam int PW = DIST_WIDTH + jlcbf_pkg::GAIN_WIDTH + 1;

  localparam logic signed [PW-1:0] VMAX_EXT =
    {{(PW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [PW-1:0] VMIN_EXT =
    {{(PW-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};

  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] prod_nxt;
  logic signed [PW-1:0] scaled;

  assign prod_nxt = PW'(gap) * $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Arithmetic shift floors toward minus infinity, as the bound requires.
  always_comb begin
    scaled = prod_r >>> jlcbf_pkg::FRAC_BITS;
    if (scaled > VMAX_EXT) begin
      bound = VMAX_EXT[VALUE_WIDTH-1:0];
    end else if (scaled < VMIN_EXT) begin
      bound = VMIN_EXT[VALUE_WIDTH-1:0];
    end else begin
      bound = scaled[VALUE_WIDTH-1:0];
    end
  end

endmodule

// File: rtl/core/joint_limit_cbf_feasibility.sv
// Top level of the joint-limit control barrier feasibility checker.
//
// Usage: one joint is offered per word on the in_ ports together with start.
// The word is taken at a rising edge where start is high and busy is low.
// busy is high during reset, is cleared by a register once reset is released,
// and stays low from then on, so a new joint may be offered in every cycle.
// Each joint gives exactly one result word. It appears on the out_ ports for
// a single cycle with out_strobe high, after the input, edge and band test,
// product and output registers, and is taken at the rising edge ending it.
// Throughput is one joint per cycle; the pipeline is built from four register
// stages: input register, edge and band test, the two gain multipliers, and
// the saturate and merge stage feeding the output register.
// The receiver cannot stall the block; a result must be taken when strobed.
// The cfg_ port writes the safety distance, influence distance and both
// gains. Writes take effect at once and should be made while no joint is in
// flight. Reset empties the pipeline and restores the register defaults.
module joint_limit_cbf_feasibility #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        start,
  output logic                                        busy,
  input  logic signed [VALUE_WIDTH-1:0]               in_joint_position,
  input  logic signed [VALUE_WIDTH-1:0]               in_position_min,
  input  logic signed [VALUE_WIDTH-1:0]               in_position_max,
  input  logic signed [VALUE_WIDTH-1:0]               in_velocity_min,
  input  logic signed [VALUE_WIDTH-1:0]               in_velocity_max,
  input  logic                                        cfg_we,
  input  logic        [jlcbf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic        [jlcbf_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
  output logic                                        out_strobe,
  output logic                                        out_feasible,
  output logic                                        out_checked,
  output logic                                        out_lower_active,
  output logic                                        out_upper_active,
  output logic signed [VALUE_WIDTH-1:0]               out_merged_lower,
  output logic signed [VALUE_WIDTH-1:0]               out_merged_upper
);

  // Distances need room for a limit plus a 31-bit margin, minus the position.
  localparam int DIST_WIDTH = ((VALUE_WIDTH > 32) ? VALUE_WIDTH : 32) + 2;

  // Configuration registers.
  logic [jlcbf_pkg::DIST_CFG_WIDTH-1:0] safe_margin_r;
  logic [jlcbf_pkg::DIST_CFG_WIDTH-1:0] band_reach_r;
  logic [jlcbf_pkg::GAIN_WIDTH-1:0]     gain_lower_r;
  logic [jlcbf_pkg::GAIN_WIDTH-1:0]     gain_upper_r;

  logic busy_r;
  logic accept;

  // Stage 0: input register.
  logic                          s0_valid_r;
  logic signed [VALUE_WIDTH-1:0] s0_position_r, s0_pmin_r, s0_pmax_r;
  logic signed [VALUE_WIDTH-1:0] s0_vmin_r, s0_vmax_r;

  // Stage 1: edge and band test.
  logic                          s1_valid_r;
  logic signed [VALUE_WIDTH-1:0] s1_vmin_r, s1_vmax_r;
  logic signed [DIST_WIDTH-1:0]  s1_dist_lower_r, s1_dist_upper_r;
  jlcbf_pkg::joint_flags_t       s1_flags_r;

  // Stage 2: products.
  logic                          s2_valid_r;
  logic signed [VALUE_WIDTH-1:0] s2_vmin_r, s2_vmax_r;
  jlcbf_pkg::joint_flags_t       s2_flags_r;
  logic signed [VALUE_WIDTH-1:0] bound_lower, bound_upper;

  // Stage 3: merged result.
  logic                          out_strobe_r;
  logic                          out_feasible_r, out_checked_r;
  logic                          out_lower_active_r, out_upper_active_r;
  logic signed [VALUE_WIDTH-1:0] out_merged_lower_r, out_merged_upper_r;
  logic signed [VALUE_WIDTH-1:0] merged_lower_nxt, merged_upper_nxt;
  logic                          feasible_nxt;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // Register writes keep only the low bits that fit each register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      safe_margin_r <= '0;
      band_reach_r  <= '0;
      gain_lower_r  <= jlcbf_pkg::GAIN_RESET;
      gain_upper_r  <= jlcbf_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      unique case (jlcbf_pkg::cfg_reg_t'(cfg_index))
        jlcbf_pkg::REG_SAFE_MARGIN: begin
          safe_margin_r <= cfg_wdata[jlcbf_pkg::DIST_CFG_WIDTH-1:0];
        end
        jlcbf_pkg::REG_BAND_REACH: begin
          band_reach_r <= cfg_wdata[jlcbf_pkg::DIST_CFG_WIDTH-1:0];
        end
        jlcbf_pkg::REG_GAIN_LOWER: begin
          gain_lower_r <= cfg_wdata[jlcbf_pkg::GAIN_WIDTH-1:0];
        end
        jlcbf_pkg::REG_GAIN_UPPER: begin
          gain_upper_r <= cfg_wdata[jlcbf_pkg::GAIN_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Valid bits of the pipeline, and busy, which is set in reset and cleared after it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      s0_valid_r   <= 1'b0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= 1'b0;
      s0_valid_r   <= accept;
      s1_valid_r   <= s0_valid_r;
      s2_valid_r   <= s1_valid_r;
      out_strobe_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_position_r <= in_joint_position;
      s0_pmin_r     <= in_position_min;
      s0_pmax_r     <= in_position_max;
      s0_vmin_r     <= in_velocity_min;
      s0_vmax_r     <= in_velocity_max;
    end
    s1_vmin_r  <= s0_vmin_r;
    s1_vmax_r  <= s0_vmax_r;
    s2_vmin_r  <= s1_vmin_r;
    s2_vmax_r  <= s1_vmax_r;
    s2_flags_r <= s1_flags_r;
  end

  jlcbf_margin #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIST_WIDTH  (DIST_WIDTH)
  ) u_margin (
    .clk            (clk),
    .joint_position (s0_position_r),
    .position_min   (s0_pmin_r),
    .position_max   (s0_pmax_r),
    .safe_margin    (safe_margin_r),
    .band_reach     (band_reach_r),
    .dist_lower_r   (s1_dist_lower_r),
    .dist_upper_r   (s1_dist_upper_r),
    .flags_r        (s1_flags_r)
  );

  jlcbf_bound #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIST_WIDTH  (DIST_WIDTH)
  ) u_bound_lower (
    .clk   (clk),
    .gain  (gain_lower_r),
    .gap   (s1_dist_lower_r),
    .bound (bound_lower)
  );

  jlcbf_bound #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIST_WIDTH  (DIST_WIDTH)
  ) u_bound_upper (
    .clk   (clk),
    .gain  (gain_upper_r),
    .gap   (s1_dist_upper_r),
    .bound (bound_upper)
  );

  // A skipped joint has both active flags clear, so the velocity box passes
  // through unchanged and only the feasibility verdict needs forcing.
  always_comb begin
    if (s2_flags_r.lower_active && (bound_lower > s2_vmin_r)) begin
      merged_lower_nxt = bound_lower;
    end else begin
      merged_lower_nxt = s2_vmin_r;
    end
    if (s2_flags_r.upper_active && (bound_upper < s2_vmax_r)) begin
      merged_upper_nxt = bound_upper;
    end else begin
      merged_upper_nxt = s2_vmax_r;
    end
    feasible_nxt = !s2_flags_r.checked || (merged_lower_nxt <= merged_upper_nxt);
  end

  always_ff @(posedge clk) begin
    out_feasible_r     <= feasible_nxt;
    out_checked_r      <= s2_flags_r.checked;
    out_lower_active_r <= s2_flags_r.lower_active;
    out_upper_active_r <= s2_flags_r.upper_active;
    out_merged_lower_r <= merged_lower_nxt;
    out_merged_upper_r <= merged_upper_nxt;
  end

  assign out_strobe       = out_strobe_r;
  assign out_feasible     = out_feasible_r;
  assign out_checked      = out_checked_r;
  assign out_lower_active = out_lower_active_r;
  assign out_upper_active = out_upper_active_r;
  assign out_merged_lower = out_merged_lower_r;
  assign out_merged_upper = out_merged_upper_r;

endmodule

// File: rtl/core/jlcbf_checker.sv
// Port-level checker for the joint-limit feasibility block, bound to the top level.
`include "assert_macros.svh"

module jlcbf_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_strobe,
  input logic                          out_feasible,
  input logic                          out_checked,
  input logic                          out_lower_active,
  input logic                          out_upper_active,
  input logic signed [VALUE_WIDTH-1:0] out_merged_lower,
  input logic signed [VALUE_WIDTH-1:0] out_merged_upper
);

  `ASSERT_IMPLIES(a_ready_after_reset, clk, rst_n, $past(rst_n), !busy)
  `ASSERT_IMPLIES(a_word_returns, clk, rst_n, start && !busy, ##4 out_strobe)
  `ASSERT_IMPLIES(a_no_spurious_word, clk, rst_n, out_strobe, $past(start && !busy, 4))
  `ASSERT_IMPLIES(a_skip_is_plain, clk, rst_n, out_strobe && !out_checked, out_feasible && !out_lower_active && !out_upper_active)
  `ASSERT_IMPLIES(a_feasible_ordered, clk, rst_n, out_strobe && out_checked && out_feasible, out_merged_lower <= out_merged_upper)

endmodule

bind joint_limit_cbf_feasibility jlcbf_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_jlcbf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_feasible     (out_feasible),
  .out_checked      (out_checked),
  .out_lower_active (out_lower_active),
  .out_upper_active (out_upper_active),
  .out_merged_lower (out_merged_lower),
  .out_merged_upper (out_merged_upper)
);

// File: test/tb_joint_limit_cbf_feasibility.sv
// Self-checking testbench for the joint-limit barrier feasibility checker.
module tb_joint_limit_cbf_feasibility;

  // The block is built at its default value width; the checking below is
  // written in 64-bit arithmetic, which holds every intermediate sum and
  // product exactly at this width.
  localparam int VW = 32;
  localparam longint ONE = longint'(1) <<< jlcbf_pkg::FRAC_BITS;
  localparam longint VAL_MAX = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint VAL_MIN = -VAL_MAX - 1;

  // Random part: several phases, each with a setting of its own.
  localparam int RANDOM_PHASES = 9;
  localparam int WORDS_PER_PHASE = 150;
  // Quiet cycles tolerated before the run is declared hung.  The longest
  // correct quiet stretch is a sender gap plus the pipeline depth.
  localparam int QUIET_LIMIT = 2000;

  typedef logic signed [VW-1:0] value_t;
  typedef logic [jlcbf_pkg::CFG_DATA_WIDTH-1:0] cfg_word_t;

  typedef struct packed {
    value_t position;
    value_t pos_min;
    value_t pos_max;
    value_t vel_min;
    value_t vel_max;
  } joint_word_t;

  typedef struct packed {
    logic   feasible;
    logic   checked;
    logic   lower_active;
    logic   upper_active;
    value_t merged_lower;
    value_t merged_upper;
  } verdict_t;

  // One row of the directed table.  Where typed is set, want holds the
  // result written out by hand; otherwise the predictor supplies it.
  typedef struct {
    int          setting;
    joint_word_t word;
    bit          typed;
    verdict_t    want;
  } stim_row_t;

  logic                                  clk = 1'b0;
  logic                                  rst_n = 1'b0;
  logic                                  start = 1'b0;
  logic                                  busy;
  value_t                                in_joint_position = '0;
  value_t                                in_position_min = '0;
  value_t                                in_position_max = '0;
  value_t                                in_velocity_min = '0;
  value_t                                in_velocity_max = '0;
  logic                                  cfg_we = 1'b0;
  logic [jlcbf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = jlcbf_pkg::REG_SAFE_MARGIN;
  cfg_word_t                             cfg_wdata = '0;
  logic                                  out_strobe;
  logic                                  out_feasible;
  logic                                  out_checked;
  logic                                  out_lower_active;
  logic                                  out_upper_active;
  value_t                                out_merged_lower;
  value_t                                out_merged_upper;

  // Our own copy of the four registers, kept at their hardware widths.
  logic [jlcbf_pkg::DIST_CFG_WIDTH-1:0] safety_margin = '0;
  logic [jlcbf_pkg::DIST_CFG_WIDTH-1:0] influence_band = '0;
  logic [jlcbf_pkg::GAIN_WIDTH-1:0]     gain_toward_lower = jlcbf_pkg::GAIN_RESET;
  logic [jlcbf_pkg::GAIN_WIDTH-1:0]     gain_toward_upper = jlcbf_pkg::GAIN_RESET;

  verdict_t  pending_verdicts[$];
  stim_row_t directed_rows[$];
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        burst_left = 0;
  verdict_t  oldest;

  joint_limit_cbf_feasibility #(
    .VALUE_WIDTH(VW)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_joint_position(in_joint_position),
    .in_position_min  (in_position_min),
    .in_position_max  (in_position_max),
    .in_velocity_min  (in_velocity_min),
    .in_velocity_max  (in_velocity_max),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_strobe       (out_strobe),
    .out_feasible     (out_feasible),
    .out_checked      (out_checked),
    .out_lower_active (out_lower_active),
    .out_upper_active (out_upper_active),
    .out_merged_lower (out_merged_lower),
    .out_merged_upper (out_merged_upper)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp_value(longint v);
    if (v > VAL_MAX) return VAL_MAX;
    if (v < VAL_MIN) return VAL_MIN;
    return v;
  endfunction

  // Barrier bound: gain times distance, shifted down by the fraction bits
  // with rounding towards minus infinity, then saturated to the value range.
  // Gain and distance are small enough that the 64-bit product is exact.
  function automatic longint barrier_bound(logic [jlcbf_pkg::GAIN_WIDTH-1:0] gain,
                                           longint gap);
    longint p;
    p = longint'(gain) * gap;
    p = p >>> jlcbf_pkg::FRAC_BITS;
    return clamp_value(p);
  endfunction

  // Expected result word for one joint under the current register copy.
  function automatic verdict_t feasibility_of(joint_word_t w);
    verdict_t v;
    longint   q, lim_lo, lim_hi, safe_lo, safe_hi, vel_lo, vel_hi, bound;
    q      = w.position;
    lim_lo = w.pos_min;
    lim_hi = w.pos_max;
    vel_lo = w.vel_min;
    vel_hi = w.vel_max;
    v = '0;
    v.feasible = 1'b1;
    // Inverted or equal limits and an empty safe band all leave the joint unchecked,
    // with the velocity box passed through and reported as feasible.
    if (lim_lo < lim_hi) begin
      safe_lo = lim_lo + longint'(safety_margin);
      safe_hi = lim_hi - longint'(safety_margin);
      if (safe_lo < safe_hi) begin
        v.checked = 1'b1;
        if (q <= lim_lo + longint'(influence_band)) begin
          v.lower_active = 1'b1;
          bound = barrier_bound(gain_toward_lower, safe_lo - q);
          if (bound > vel_lo) vel_lo = bound;
        end
        if (q >= lim_hi - longint'(influence_band)) begin
          v.upper_active = 1'b1;
          bound = barrier_bound(gain_toward_upper, safe_hi - q);
          if (bound < vel_hi) vel_hi = bound;
        end
        v.feasible = (vel_lo <= vel_hi);
      end
    end
    v.merged_lower = value_t'(vel_lo);
    v.merged_upper = value_t'(vel_hi);
    return v;
  endfunction

  // A random magnitude below two to the power of bits.
  function automatic longint magnitude(int bits);
    return longint'($urandom) & ((longint'(1) <<< bits) - 1);
  endfunction

  function automatic longint signed_mag(int bits);
    longint m;
    m = magnitude(bits);
    return ($urandom_range(0, 1) == 1) ? -m : m;
  endfunction

  // Mostly well-formed joints whose limits, position and velocity box sit at
  // the scale of the current setting, so that the band tests, the barrier
  // products and the merge are all reached.  One word in sixteen is pure
  // noise and a further one in sixteen has its limits swapped.
  function automatic joint_word_t random_joint(int scale);
    joint_word_t w;
    int          kind, s;
    longint      pmin, pmax, q, span, vmid, vmin, vmax, tmp;
    kind = $urandom_range(0, 15);
    s = $urandom_range((scale > 2) ? scale - 2 : 0, (scale < 28) ? scale + 2 : 30);
    if (kind == 0) begin
      w = {$urandom, $urandom, $urandom, $urandom, $urandom};
      return w;
    end
    pmin = ($urandom_range(0, 7) == 0) ? signed_mag(31) : signed_mag(s + 1);
    if ($urandom_range(0, 3) == 0) span = magnitude(s);
    else span = 2 * longint'(safety_margin) + magnitude(s + 1) + 1;
    pmax = clamp_value(pmin + span);
    if (kind == 1) begin
      tmp = pmin;
      pmin = pmax;
      pmax = tmp;
    end
    // Aim the position at a limit, at an edge of the influence band (give or
    // take one step, to hit the equality cases), or anywhere inside.
    case ($urandom_range(0, 4))
      0: q = pmin + signed_mag(s);
      1: q = pmax + signed_mag(s);
      2: q = pmin + longint'(influence_band) + longint'($urandom_range(0, 2)) - 1;
      3: q = pmax - longint'(influence_band) + longint'($urandom_range(0, 2)) - 1;
      default: begin
        if (pmax > pmin) q = pmin + longint'($urandom) % (pmax - pmin + 1);
        else q = pmin;
      end
    endcase
    vmid = signed_mag(s + 1);
    vmin = clamp_value(vmid - magnitude(s));
    vmax = clamp_value(vmid + magnitude(s));
    case ($urandom_range(0, 9))
      0: begin
        tmp = vmin;
        vmin = vmax;
        vmax = tmp;
      end
      1: vmin = VAL_MIN;
      2: vmax = VAL_MAX;
      default: ;
    endcase
    w.position = value_t'(clamp_value(q));
    w.pos_min  = value_t'(pmin);
    w.pos_max  = value_t'(pmax);
    w.vel_min  = value_t'(vmin);
    w.vel_max  = value_t'(vmax);
    return w;
  endfunction

  task automatic add_row(int setting, longint q, longint pmin, longint pmax,
                         longint vmin, longint vmax, bit typed,
                         logic [3:0] flags, longint lo, longint hi);
    stim_row_t r;
    r.setting = setting;
    r.word = {value_t'(q), value_t'(pmin), value_t'(pmax), value_t'(vmin), value_t'(vmax)};
    r.typed = typed;
    r.want = {flags, value_t'(lo), value_t'(hi)};
    directed_rows.push_back(r);
  endtask

  // Writes all four registers on consecutive edges, keeping the enable high
  // throughout, and mirrors each write into the local copy as it lands.
  task automatic program_regs(cfg_word_t sd, cfg_word_t id, cfg_word_t gl, cfg_word_t gu);
    jlcbf_pkg::cfg_reg_t order [4] = '{jlcbf_pkg::REG_SAFE_MARGIN,
                                       jlcbf_pkg::REG_BAND_REACH,
                                       jlcbf_pkg::REG_GAIN_LOWER,
                                       jlcbf_pkg::REG_GAIN_UPPER};
    cfg_word_t           vals  [4];
    vals = '{sd, id, gl, gu};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      case (order[i])
        jlcbf_pkg::REG_SAFE_MARGIN:
          safety_margin = vals[i][jlcbf_pkg::DIST_CFG_WIDTH-1:0];
        jlcbf_pkg::REG_BAND_REACH:
          influence_band = vals[i][jlcbf_pkg::DIST_CFG_WIDTH-1:0];
        jlcbf_pkg::REG_GAIN_LOWER:
          gain_toward_lower = vals[i][jlcbf_pkg::GAIN_WIDTH-1:0];
        jlcbf_pkg::REG_GAIN_UPPER:
          gain_toward_upper = vals[i][jlcbf_pkg::GAIN_WIDTH-1:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // Offers one word and returns just after the edge that accepts it.  The
  // expectation is formed at that edge, from the registers then in force.
  // start is left high so that a following word can go straight on.
  task automatic send_joint(joint_word_t w, bit typed, verdict_t want);
    in_joint_position <= w.position;
    in_position_min   <= w.pos_min;
    in_position_max   <= w.pos_max;
    in_velocity_min   <= w.vel_min;
    in_velocity_max   <= w.vel_max;
    start             <= 1'b1;
    do @(posedge clk); while (busy);
    pending_verdicts.push_back(typed ? want : feasibility_of(w));
  endtask

  // The sender works in bursts; between bursts it drops start for a random
  // gap.  In a steady phase it never idles.
  task automatic pace(bit steady);
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // Holds off the sender until every outstanding result has been seen.  As
  // each word yields exactly one result, the block is then idle.
  task automatic settle();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(string name, logic signed [63:0] want,
                               logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result checker.  Outputs are sampled at the edge that ends the strobed
  // cycle, before the block updates them.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result word with no expectation waiting, expected none, got %0d %0d",
                 $time, out_merged_lower, out_merged_upper);
        mismatches++;
      end else begin
        oldest = pending_verdicts.pop_front();
        compare_field("feasible", oldest.feasible, out_feasible);
        compare_field("checked", oldest.checked, out_checked);
        compare_field("lower_active", oldest.lower_active, out_lower_active);
        compare_field("upper_active", oldest.upper_active, out_upper_active);
        compare_field("merged_lower", oldest.merged_lower, out_merged_lower);
        compare_field("merged_upper", oldest.merged_upper, out_merged_upper);
      end
    end
  end

  // Watchdog: any accepted word, in either direction, counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog expired after %0d quiet cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int scale;
    int current;
    bit steady;

    // Directed table.  Setting 0 is the state left by reset (no margins,
    // unit gains); settings 1 to 4 are written before their rows.
    // Flags are feasible, checked, lower active, upper active.
    // Inverted and equal limits skip the joint, even with an inverted box.
    add_row(0, 0, ONE, -ONE, 5, -5, 1, 4'b1000, 5, -5);
    add_row(0, 0, 0, 0, VAL_MIN, VAL_MAX, 1, 4'b1000, VAL_MIN, VAL_MAX);
    // Well inside the limits: no barrier applies, the box passes through.
    add_row(0, 0, -ONE, ONE, -100, 100, 1, 4'b1100, -100, 100);
    add_row(0, 0, -ONE, ONE, 100, -100, 1, 4'b0100, 100, -100);
    // Exactly on each limit the barrier bound is zero.
    add_row(0, -ONE, -ONE, ONE, -ONE, ONE, 1, 4'b1110, 0, ONE);
    add_row(0, ONE, -ONE, ONE, -ONE, ONE, 1, 4'b1101, -ONE, 0);
    // Beyond a limit the unit gain gives the distance back as the bound.
    add_row(0, -2 * ONE, -ONE, ONE, 0, 2 * ONE, 1, 4'b1110, ONE, 2 * ONE);
    add_row(0, 3 * ONE, -ONE, ONE, -ONE, 2 * ONE, 1, 4'b0101, -ONE, -2 * ONE);
    // Field extremes.
    add_row(0, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, 1, 4'b1110, 0, VAL_MAX);
    add_row(0, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN, 1, 4'b0101, VAL_MAX, VAL_MIN);
    add_row(0, -1, -1, -1, -1, -1, 1, 4'b1000, -1, -1);
    // Setting 1: a safe band that just closes, one step wide, and gains of
    // two and one half with fractional positions to exercise rounding.
    add_row(1, 0, 0, 2 * ONE, -ONE, ONE, 1, 4'b1000, -ONE, ONE);
    add_row(1, ONE, 0, 2 * ONE + 1, -ONE, ONE, 0, '0, 0, 0);
    add_row(1, ONE / 2 + 1, 0, 10 * ONE, -4 * ONE, 4 * ONE, 0, '0, 0, 0);
    add_row(1, 5 * ONE - 3, 0, 8 * ONE, -4 * ONE, 4 * ONE, 0, '0, 0, 0);
    add_row(1, 9 * ONE + 32769, 0, 10 * ONE, VAL_MIN, VAL_MAX, 0, '0, 0, 0);
    // Setting 2: every register at its top value.
    add_row(2, 0, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, 0, '0, 0, 0);
    add_row(2, VAL_MIN, VAL_MIN, VAL_MAX, 0, 0, 0, '0, 0, 0);
    add_row(2, 0, VAL_MIN + 1, VAL_MAX, VAL_MIN, VAL_MAX, 0, '0, 0, 0);
    // Setting 3: top gains and a wide band, so both products saturate.
    add_row(3, VAL_MIN, 0, VAL_MAX, VAL_MIN, VAL_MAX, 0, '0, 0, 0);
    add_row(3, VAL_MAX, VAL_MIN, 0, VAL_MIN, VAL_MAX, 0, '0, 0, 0);
    add_row(3, -ONE, 0, ONE, -ONE, ONE, 0, '0, 0, 0);
    // Setting 4: zero gains pin any active bound to zero.
    add_row(4, -2 * ONE, -ONE, ONE, -ONE, ONE, 0, '0, 0, 0);
    add_row(4, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5556, 32'shAAAA_AAAA,
            32'sh5555_5555, 0, '0, 0, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    current = 0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].setting != current) begin
        settle();
        current = directed_rows[i].setting;
        case (current)
          1: program_regs(cfg_word_t'(ONE), cfg_word_t'(4 * ONE),
                          cfg_word_t'(2 * ONE), cfg_word_t'(ONE / 2));
          2: program_regs('1, '1, '1, '1);
          3: program_regs('0, '1, cfg_word_t'(24'hFF_FFFF), cfg_word_t'(24'hFF_FFFF));
          4: program_regs('0, '0, '0, '0);
          default: ;
        endcase
      end
      send_joint(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
      pace(1'b0);
    end

    // Random phases.  Each starts from an idle block with a fresh setting:
    // margins and bands at a common scale, gains mostly up to four, and now
    // and then a raw value whose upper bits the gain registers must drop.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      scale = $urandom_range(4, 28);
      program_regs(($urandom_range(0, 3) == 0) ? '0 : cfg_word_t'(magnitude(scale - 2)),
                   cfg_word_t'(magnitude(scale + 1)),
                   ($urandom_range(0, 4) == 0) ? cfg_word_t'($urandom)
                                               : cfg_word_t'($urandom_range(0, 32'(4 * ONE))),
                   ($urandom_range(0, 4) == 0) ? cfg_word_t'($urandom)
                                               : cfg_word_t'($urandom_range(0, 32'(4 * ONE))));
      steady = (ph % 4 == 2);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        send_joint(random_joint(scale), 1'b0, '0);
        pace(steady);
      end
    end

    // Let the pipeline empty, then keep the clock running to catch any stray word.
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/jlcbf_pkg.sv
rtl/core/jlcbf_margin.sv
rtl/core/jlcbf_bound.sv
rtl/core/joint_limit_cbf_feasibility.sv
rtl/core/jlcbf_checker.sv
test/tb_joint_limit_cbf_feasibility.sv
